[rtl/edft_pkg.sv]
// ---------------------------------------------------------------------------
// EDF tick scheduler package
// Shared sizes, register indexes and task field helpers.
// ---------------------------------------------------------------------------
package edft_pkg;

   localparam int MAX_TASKS      = 8;
   localparam int TIME_BITS      = 10;
   localparam int FIELD_BITS     = 10;
   localparam int TASK_BITS      = 3 * FIELD_BITS;
   localparam int SLOT_COUNT     = 8;
   localparam int TASK_REG_COUNT = SLOT_COUNT / 2;
   localparam int REG_BITS       = 2 * TASK_BITS;
   localparam int ACTIVE_BITS    = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int TASK_ID_BITS   = 3;
   localparam int MISS_BITS      = 8;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_TASKS    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TASKS_ZERO_ONE  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TASKS_TWO_THREE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TASKS_FOUR_FIVE = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TASKS_SIX_SEVEN = 3'd4;

   // field selectors within one task
   localparam int FIELD_EXEC     = 0;
   localparam int FIELD_DEADLINE = 1;
   localparam int FIELD_PERIOD   = 2;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [TASK_REG_COUNT-1:0][REG_BITS-1:0] task_regs_type;

   // pull one 10-bit field of one task and fit it to the counter width
   function automatic time_type task_field(input task_regs_type regs, input int task_id,
                                           input int which);
      logic [REG_BITS-1:0]   reg_word;
      logic [FIELD_BITS-1:0] raw;
      logic [15:0]           wide;
      reg_word = regs[task_id >> 1];
      raw      = reg_word[(task_id & 1) * TASK_BITS + which * FIELD_BITS +: FIELD_BITS];
      wide     = 16'(raw);
      return wide[TIME_BITS-1:0];
   endfunction

endpackage

[rtl/edf_tick_scheduler_core.sv]
// ---------------------------------------------------------------------------
// EDF tick scheduler core
// Earliest-deadline-first selection and counter update for periodic tasks.
// ---------------------------------------------------------------------------
// Result beats are registered: a result beat appears in the cycle after its request beat is taken.
// Throughput: one tick per cycle unless a held result stalls the request side; the
//   combinational 8-way deadline compare and counter update close the loop on the task state.
// Reset (synchronous, active high): clears configuration, all task counters
//   and the result valid; request stall is held high while in reset.
module edf_tick_scheduler_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration write port
   input  logic                                   csr_we,
   input  logic [edft_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [edft_pkg::REG_BITS-1:0]          csr_wdata,
   // tick requests
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_restart,
   // schedule results
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [edft_pkg::TASK_ID_BITS-1:0]      rsp_running_task,
   output logic                                   rsp_idle,
   output logic [edft_pkg::MISS_BITS-1:0]         rsp_miss_mask
);

   // configuration
   logic [edft_pkg::ACTIVE_BITS-1:0] active_tasks_ff;
   edft_pkg::task_regs_type          task_regs_ff;

   // per-task counters, one lane per task
   edft_pkg::time_type cap_ff   [edft_pkg::MAX_TASKS];
   edft_pkg::time_type dl_ff    [edft_pkg::MAX_TASKS];
   edft_pkg::time_type phase_ff [edft_pkg::MAX_TASKS];
   edft_pkg::time_type cap_in   [edft_pkg::MAX_TASKS];
   edft_pkg::time_type dl_in    [edft_pkg::MAX_TASKS];
   edft_pkg::time_type phase_in [edft_pkg::MAX_TASKS];

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [edft_pkg::TASK_ID_BITS-1:0]   running_ff, running_in;
   logic                                idle_ff, idle_in;
   logic [edft_pkg::MISS_BITS-1:0]      miss_ff, miss_in;

   logic take;

   // Hold the request side in reset and while a finished beat waits downstream.
   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign take      = req_valid & ~req_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_running_task = running_ff;
   assign rsp_idle         = idle_ff;
   assign rsp_miss_mask    = miss_ff;

   // ------------------------------------------------------------------
   // Configuration writes; unknown indexes drop silently.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         active_tasks_ff <= '0;
         task_regs_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            edft_pkg::CSR_ACTIVE_TASKS: begin
               active_tasks_ff <= csr_wdata[edft_pkg::ACTIVE_BITS-1:0];
            end
            edft_pkg::CSR_TASKS_ZERO_ONE: begin
               task_regs_ff[0] <= csr_wdata;
            end
            edft_pkg::CSR_TASKS_TWO_THREE: begin
               task_regs_ff[1] <= csr_wdata;
            end
            edft_pkg::CSR_TASKS_FOUR_FIVE: begin
               task_regs_ff[2] <= csr_wdata;
            end
            edft_pkg::CSR_TASKS_SIX_SEVEN: begin
               task_regs_ff[3] <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // One tick: optional restart, EDF pick, service, then period/deadline
   // advance for every active lane.
   // ------------------------------------------------------------------
   always_comb begin
      logic [edft_pkg::ACTIVE_BITS-1:0]  n;
      edft_pkg::time_type                cap0   [edft_pkg::MAX_TASKS];
      edft_pkg::time_type                dl0    [edft_pkg::MAX_TASKS];
      edft_pkg::time_type                ph0    [edft_pkg::MAX_TASKS];
      edft_pkg::time_type                cap1   [edft_pkg::MAX_TASKS];
      edft_pkg::time_type                best;
      edft_pkg::time_type                period;
      edft_pkg::time_type                period_last;
      logic                              found;
      logic [edft_pkg::TASK_ID_BITS-1:0] pick;
      logic [edft_pkg::MISS_BITS-1:0]    miss;

      // clamp the task count to the lanes that exist
      if (active_tasks_ff > edft_pkg::ACTIVE_BITS'(edft_pkg::MAX_TASKS)) begin
         n = edft_pkg::ACTIVE_BITS'(edft_pkg::MAX_TASKS);
      end else begin
         n = active_tasks_ff;
      end

      // restart reloads every lane before the tick
      for (int t = 0; t < edft_pkg::MAX_TASKS; t++) begin
         if (req_restart) begin
            cap0[t] = edft_pkg::task_field(task_regs_ff, t, edft_pkg::FIELD_EXEC);
            dl0[t]  = edft_pkg::task_field(task_regs_ff, t, edft_pkg::FIELD_DEADLINE);
            ph0[t]  = '0;
         end else begin
            cap0[t] = cap_ff[t];
            dl0[t]  = dl_ff[t];
            ph0[t]  = phase_ff[t];
         end
      end

      // smallest countdown among lanes with capacity; strict less keeps
      // the lowest index on ties
      found = 1'b0;
      best  = '0;
      pick  = '0;
      for (int t = 0; t < edft_pkg::MAX_TASKS; t++) begin
         if ((edft_pkg::ACTIVE_BITS'(t) < n) && (cap0[t] != '0) &&
             (!found || (dl0[t] < best))) begin
            found = 1'b1;
            best  = dl0[t];
            pick  = edft_pkg::TASK_ID_BITS'(t);
         end
      end

      // take one unit from the winner only
      for (int t = 0; t < edft_pkg::MAX_TASKS; t++) begin
         if (found && (pick == edft_pkg::TASK_ID_BITS'(t))) begin
            cap1[t] = cap0[t] - 1'b1;
         end else begin
            cap1[t] = cap0[t];
         end
      end

      // reload at period end, else count the deadline down and flag misses
      miss = '0;
      for (int t = 0; t < edft_pkg::MAX_TASKS; t++) begin
         period      = edft_pkg::task_field(task_regs_ff, t, edft_pkg::FIELD_PERIOD);
         period_last = period - 1'b1;
         cap_in[t]   = cap1[t];
         dl_in[t]    = dl0[t];
         phase_in[t] = ph0[t];
         if (edft_pkg::ACTIVE_BITS'(t) < n) begin
            if ((period != '0) && (ph0[t] == period_last)) begin
               cap_in[t]   = edft_pkg::task_field(task_regs_ff, t, edft_pkg::FIELD_EXEC);
               dl_in[t]    = edft_pkg::task_field(task_regs_ff, t,
                                                  edft_pkg::FIELD_DEADLINE);
               phase_in[t] = '0;
            end else begin
               if (dl0[t] != '0) begin
                  dl_in[t] = dl0[t] - 1'b1;
               end else if (cap1[t] != '0) begin
                  miss[t] = 1'b1;
               end
               phase_in[t] = ph0[t] + 1'b1;
            end
         end
      end

      running_in = found ? pick : '0;
      idle_in    = ~found;
      miss_in    = miss;
   end

   // Advance the task state on every taken beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < edft_pkg::MAX_TASKS; t++) begin
            cap_ff[t]   <= '0;
            dl_ff[t]    <= '0;
            phase_ff[t] <= '0;
         end
      end else if (take) begin
         for (int t = 0; t < edft_pkg::MAX_TASKS; t++) begin
            cap_ff[t]   <= cap_in[t];
            dl_ff[t]    <= dl_in[t];
            phase_ff[t] <= phase_in[t];
         end
      end
   end

   // Result beat: load on take, hold while the consumer stalls.
   assign rsp_valid_in = take | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         running_ff <= running_in;
         idle_ff    <= idle_in;
         miss_ff    <= miss_in;
      end
   end

endmodule

[rtl/edft_checker.sv]
// ---------------------------------------------------------------------------
// EDF tick scheduler checker
// Port-level properties of the scheduler core, attached by bind.
// ---------------------------------------------------------------------------
module edft_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [edft_pkg::TASK_ID_BITS-1:0]   rsp_running_task,
   input logic                                rsp_idle,
   input logic [edft_pkg::MISS_BITS-1:0]      rsp_miss_mask
);

   // an idle beat reports task zero
   assert property (@(posedge clock) (rsp_valid && rsp_idle) |-> (rsp_running_task == '0))
      else $error("idle beat with nonzero running task");

   // reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // requests stall only behind a held result
   assert property (@(posedge clock) (!reset && req_stall) |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held result");

   // every taken tick produces a result next cycle
   assert property (@(posedge clock) disable iff (reset)
                    (req_valid && !req_stall) |=> rsp_valid)
      else $error("taken tick produced no result");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_stall) |=>
                    (rsp_valid && $stable(rsp_running_task) && $stable(rsp_idle) &&
                     $stable(rsp_miss_mask)))
      else $error("stalled result beat changed");

endmodule

bind edf_tick_scheduler_core edft_checker u_edft_checker (.*);

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// EDF tick scheduler core testbench
// Drives tick request beats from a queue and tracks every task counter in a
// local scheduler image. Each result beat is checked against the predicted
// pick, idle flag and miss mask. Configuration changes between drained phases.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 8;
   localparam int IDLE_PCT       = 26;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int MAX_REPORTS    = 10;
   localparam int LIMIT_CYCLES   = 200000;

   typedef struct packed {
      logic [edft_pkg::TASK_ID_BITS-1:0] running_task;
      logic                              idle;
      logic [edft_pkg::MISS_BITS-1:0]    miss_mask;
   } tick_result_type;

   // DUT connections; every input starts at a known value
   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                csr_we      = 1'b0;
   logic [edft_pkg::CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [edft_pkg::REG_BITS-1:0]       csr_wdata   = '0;
   logic                                req_valid   = 1'b0;
   logic                                req_stall;
   logic                                req_restart = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall   = 1'b0;
   logic [edft_pkg::TASK_ID_BITS-1:0]   rsp_running_task;
   logic                                rsp_idle;
   logic [edft_pkg::MISS_BITS-1:0]      rsp_miss_mask;

   // stimulus bookkeeping
   logic            restart_pending_q[$];
   tick_result_type schedule_expect_q[$];
   int              ticks_queued   = 0;
   int              ticks_accepted = 0;
   int              error_count    = 0;
   logic            no_idle        = 1'b0;
   logic            holdoff_kick   = 1'b0;
   int              holdoff_left   = 0;

   // scheduler image: configuration and per-slot counters
   logic [edft_pkg::ACTIVE_BITS-1:0] cfg_active;
   edft_pkg::task_regs_type          cfg_tasks;
   edft_pkg::time_type               slot_capacity[edft_pkg::SLOT_COUNT];
   edft_pkg::time_type               slot_deadline[edft_pkg::SLOT_COUNT];
   edft_pkg::time_type               slot_phase[edft_pkg::SLOT_COUNT];

   edf_tick_scheduler_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_running_task (rsp_running_task),
      .rsp_idle         (rsp_idle),
      .rsp_miss_mask    (rsp_miss_mask)
   );

   initial forever #(CLK_PERIOD / 2) clock = ~clock;

   // one configured parameter of one task, fitted to the counter width
   function automatic edft_pkg::time_type slot_param(input int slot, input int which);
      logic [edft_pkg::REG_BITS-1:0]   word;
      logic [edft_pkg::FIELD_BITS-1:0] raw;
      word = cfg_tasks[slot >> 1];
      raw  = word[(slot & 1) * edft_pkg::TASK_BITS + which * edft_pkg::FIELD_BITS
                  +: edft_pkg::FIELD_BITS];
      return edft_pkg::time_type'(raw);
   endfunction

   function automatic void reload_slot(input int slot);
      slot_capacity[slot] = slot_param(slot, edft_pkg::FIELD_EXEC);
      slot_deadline[slot] = slot_param(slot, edft_pkg::FIELD_DEADLINE);
      slot_phase[slot]    = '0;
   endfunction

   // advance the scheduler image by one tick and return the expected beat
   function automatic tick_result_type schedule_tick(input logic restart);
      int                             n;
      int                             pick;
      logic                           found;
      edft_pkg::time_type             best;
      edft_pkg::time_type             period;
      logic [edft_pkg::MISS_BITS-1:0] miss;
      tick_result_type                res;
      n     = (int'(cfg_active) > edft_pkg::MAX_TASKS) ? edft_pkg::MAX_TASKS
                                                       : int'(cfg_active);
      pick  = 0;
      found = 1'b0;
      best  = '0;
      miss  = '0;
      if (restart)
         for (int t = 0; t < edft_pkg::MAX_TASKS; t++) reload_slot(t);
      // earliest deadline among slots with capacity, lowest index on ties
      for (int t = 0; t < n; t++) begin
         if (slot_capacity[t] != 0 && (!found || slot_deadline[t] < best)) begin
            found = 1'b1;
            best  = slot_deadline[t];
            pick  = t;
         end
      end
      if (found) slot_capacity[pick] = slot_capacity[pick] - 1'b1;
      for (int t = 0; t < n; t++) begin
         period = slot_param(t, edft_pkg::FIELD_PERIOD);
         if (period != 0 && slot_phase[t] == edft_pkg::time_type'(period - 1'b1)) begin
            reload_slot(t);
         end else begin
            if (slot_deadline[t] != 0) slot_deadline[t] = slot_deadline[t] - 1'b1;
            else if (slot_capacity[t] != 0) miss[t] = 1'b1;
            slot_phase[t] = slot_phase[t] + 1'b1;
         end
      end
      res.running_task = found ? edft_pkg::TASK_ID_BITS'(pick) : '0;
      res.idle         = !found;
      res.miss_mask    = miss;
      return res;
   endfunction

   function automatic logic [edft_pkg::TASK_BITS-1:0] pack_task(input int exec_v,
                                                                input int dl_v,
                                                                input int per_v);
      return {edft_pkg::FIELD_BITS'(per_v), edft_pkg::FIELD_BITS'(dl_v),
              edft_pkg::FIELD_BITS'(exec_v)};
   endfunction

   // mostly short tasks so that pick, reload and miss all happen often
   function automatic logic [edft_pkg::TASK_BITS-1:0] rand_task();
      int exec_v;
      int dl_v;
      int per_v;
      exec_v = ($urandom_range(15) == 0) ? $urandom_range(1023) : $urandom_range(6);
      dl_v   = ($urandom_range(15) == 0) ? $urandom_range(1023) : $urandom_range(15);
      per_v  = ($urandom_range(15) == 0) ? $urandom_range(1023) : $urandom_range(20);
      return pack_task(exec_v, dl_v, per_v);
   endfunction

   function automatic void report_error(input string what, input tick_result_type exp_r);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR %s: exp task=%0d idle=%0d miss=%02h got task=%0d idle=%0d miss=%02h",
                  what, exp_r.running_task, exp_r.idle, exp_r.miss_mask,
                  rsp_running_task, rsp_idle, rsp_miss_mask);
   endfunction

   // Request driver: track the image on every taken beat and offer the next
   // pending tick. Hold valid and payload while stalled; never look at stall
   // to decide whether to raise valid.
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_restart <= 1'b0;
         cfg_active  = '0;
         cfg_tasks   = '0;
         for (int t = 0; t < edft_pkg::SLOT_COUNT; t++) begin
            slot_capacity[t] = '0;
            slot_deadline[t] = '0;
            slot_phase[t]    = '0;
         end
      end else begin
         // mirror register writes on the edge the DUT takes them
         if (csr_we) begin
            case (csr_index)
               edft_pkg::CSR_ACTIVE_TASKS:
                  cfg_active = csr_wdata[edft_pkg::ACTIVE_BITS-1:0];
               edft_pkg::CSR_TASKS_ZERO_ONE:  cfg_tasks[0] = csr_wdata;
               edft_pkg::CSR_TASKS_TWO_THREE: cfg_tasks[1] = csr_wdata;
               edft_pkg::CSR_TASKS_FOUR_FIVE: cfg_tasks[2] = csr_wdata;
               edft_pkg::CSR_TASKS_SIX_SEVEN: cfg_tasks[3] = csr_wdata;
               default: ;  // drop writes past the register list
            endcase
         end
         if (req_valid && !req_stall) begin
            schedule_expect_q.push_back(schedule_tick(req_restart));
            ticks_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (restart_pending_q.size() != 0 &&
                (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid   <= 1'b1;
               req_restart <= restart_pending_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here and merged into the random stall.
   always @(posedge clock) begin
      if (reset) holdoff_left <= 0;
      else if (holdoff_kick) holdoff_left <= HOLDOFF_CYCLES;
      else if (holdoff_left != 0) holdoff_left <= holdoff_left - 1;
   end

   // Result monitor: compare each taken beat with the oldest prediction.
   always @(posedge clock) begin
      tick_result_type exp_r;
      rsp_stall <= (holdoff_left != 0) || (!no_idle && $urandom_range(99) < IDLE_PCT);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (schedule_expect_q.size() == 0) begin
            report_error("unexpected result beat", '0);
         end else begin
            exp_r = schedule_expect_q.pop_front();
            if (rsp_running_task !== exp_r.running_task) report_error("running_task", exp_r);
            else if (rsp_idle !== exp_r.idle) report_error("idle", exp_r);
            else if (rsp_miss_mask !== exp_r.miss_mask) report_error("miss_mask", exp_r);
         end
      end
   end

   task automatic write_csr(input logic [edft_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [edft_pkg::REG_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // hold the sender until every tick is taken and every result is back
   task automatic wait_drain();
      while (ticks_accepted != ticks_queued || schedule_expect_q.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int restart_pct, input logic first_restart);
      for (int i = 0; i < count; i++)
         restart_pending_q.push_back((i == 0) ? first_restart
                                              : ($urandom_range(99) < restart_pct));
      ticks_queued += count;
      wait_drain();
   endtask

   task automatic randomize_config();
      logic [edft_pkg::REG_BITS-1:0] junk;
      int                            act;
      case ($urandom_range(15))
         0:       act = 0;
         1, 2:    act = $urandom_range(edft_pkg::MAX_TASKS + 1, 2**edft_pkg::ACTIVE_BITS - 1);
         default: act = $urandom_range(1, edft_pkg::MAX_TASKS);
      endcase
      // upper bits of the active count write are don't-care
      junk = edft_pkg::REG_BITS'({$urandom, $urandom});
      write_csr(edft_pkg::CSR_ACTIVE_TASKS,
                {junk[edft_pkg::REG_BITS-1:edft_pkg::ACTIVE_BITS],
                 edft_pkg::ACTIVE_BITS'(act)});
      for (int r = 0; r < edft_pkg::TASK_REG_COUNT; r++)
         if ($urandom_range(9) < 6)
            write_csr(edft_pkg::CSR_INDEX_BITS'(edft_pkg::CSR_TASKS_ZERO_ONE + r),
                      {rand_task(), rand_task()});
      if ($urandom_range(3) == 0)
         write_csr(edft_pkg::CSR_INDEX_BITS'($urandom_range(edft_pkg::CSR_TASKS_SIX_SEVEN + 1,
                                                  2**edft_pkg::CSR_INDEX_BITS - 1)),
                   edft_pkg::REG_BITS'({$urandom, $urandom}));
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // idle ticks with the reset configuration: no active tasks
      run_phase(2, 0, 1'b0);

      // three tasks: short period, tight period, zero period that keeps missing
      write_csr(edft_pkg::CSR_TASKS_ZERO_ONE, {pack_task(1, 2, 3), pack_task(2, 4, 5)});
      write_csr(edft_pkg::CSR_TASKS_TWO_THREE,
                {pack_task(1023, 1023, 1023), pack_task(3, 3, 0)});
      write_csr(edft_pkg::CSR_ACTIVE_TASKS, edft_pkg::REG_BITS'(3));
      run_phase(8, 0, 1'b1);

      // active count above the slot count; zero deadline with max capacity
      write_csr(edft_pkg::CSR_TASKS_FOUR_FIVE, {pack_task(0, 0, 0), pack_task(1023, 0, 1)});
      write_csr(edft_pkg::CSR_TASKS_SIX_SEVEN,
                {pack_task(1, 0, 2), pack_task(5, 1023, 1023)});
      write_csr(edft_pkg::CSR_ACTIVE_TASKS,
                edft_pkg::REG_BITS'(2**edft_pkg::ACTIVE_BITS - 1));
      for (int idx = edft_pkg::CSR_TASKS_SIX_SEVEN + 1; idx < 2**edft_pkg::CSR_INDEX_BITS;
           idx++)
         write_csr(edft_pkg::CSR_INDEX_BITS'(idx), '1);
      run_phase(6, 0, 1'b1);

      // all-ones tasks in the low pair, full slot count
      write_csr(edft_pkg::CSR_TASKS_ZERO_ONE, '1);
      write_csr(edft_pkg::CSR_ACTIVE_TASKS, edft_pkg::REG_BITS'(edft_pkg::MAX_TASKS));
      run_phase(4, 0, 1'b1);

      // shrink the period under the running phase without a restart
      write_csr(edft_pkg::CSR_TASKS_ZERO_ONE, {pack_task(1, 2, 1), pack_task(4, 6, 1)});
      run_phase(3, 0, 1'b0);

      // random phases with fresh configuration in between
      for (int p = 0; p < 10; p++) begin
         randomize_config();
         if (p == 3) begin
            // sender keeps offering while the receiver holds off
            no_idle      <= 1'b1;
            holdoff_kick <= 1'b1;
            @(posedge clock);
            holdoff_kick <= 1'b0;
            run_phase(100, 5, $urandom_range(9) < 7);
            no_idle      <= 1'b0;
         end else if (p == 6) begin
            // long stretch without idling on either side
            no_idle <= 1'b1;
            run_phase(150, 5, $urandom_range(9) < 7);
            no_idle <= 1'b0;
         end else begin
            run_phase(100, 5, $urandom_range(9) < 7);
         end
      end

      repeat (4) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #(CLK_PERIOD * LIMIT_CYCLES);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
